FILE: hdl/ppmfd_pkg.sv
package ppmfd_pkg;

	localparam int unsigned TICK_W = 32;
	localparam int unsigned CHAN_W = 4;
	localparam int unsigned CFG_IDX_W = 4;

	// Transaction kinds
	typedef enum logic {
		REQ_CAPTURE = 1'b0,
		REQ_READ    = 1'b1
	} req_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_MAX = 4'd3;

	// Register reset values
	localparam logic [TICK_W-1:0] SYNC_MIN_RST = 32'd5000;
	localparam logic [TICK_W-1:0] SYNC_MAX_RST = 32'd15000;
	localparam logic [TICK_W-1:0] DATA_MIN_RST = 32'd900;
	localparam logic [TICK_W-1:0] DATA_MAX_RST = 32'd2100;

	typedef struct packed {
		logic              req_type;
		logic [TICK_W-1:0] capture_time;
		logic [CHAN_W-1:0] channel_number;
	} in_t;

	typedef struct packed {
		logic              frame_valid;
		logic [TICK_W-1:0] channel_value;
		logic              channel_in_range;
	} out_t;

endpackage

FILE: hdl/ppm_frame_decoder.sv
// PPM frame decoder: one result per accepted transaction, in order.
// Pipeline: input register, then gap subtract, window compares and store update
// into the result register.
// Throughput: one transaction per cycle; stalls only when the result register is held.
// Reset (arst_n low, asynchronous): window registers to defaults, waiting for sync,
// last capture 0, valid flag 0, every stored width DEFAULT_PULSE.
module ppm_frame_decoder #(
	parameter int unsigned NUM_CHANNELS  = 8,
	parameter int unsigned DEFAULT_PULSE = 1500
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// capture / read requests
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  ppmfd_pkg::in_t                         in_data,
	// results
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output ppmfd_pkg::out_t                        out_data,
	// configuration writes
	input  logic                                   cfg_we,
	input  logic [ppmfd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ppmfd_pkg::TICK_W-1:0]           cfg_data
);

	localparam int unsigned IDX_W = $clog2(NUM_CHANNELS + 1);
	localparam int unsigned SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] IDX_WAIT = IDX_W'(NUM_CHANNELS);
	localparam logic [ppmfd_pkg::CHAN_W-1:0] CHAN_MAX = ppmfd_pkg::CHAN_W'(NUM_CHANNELS);
	localparam logic [ppmfd_pkg::TICK_W-1:0] PULSE_RST = ppmfd_pkg::TICK_W'(DEFAULT_PULSE);

	// window registers
	logic [ppmfd_pkg::TICK_W-1:0] sync_min_q, sync_max_q, data_min_q, data_max_q;

	// decoder state
	logic [IDX_W-1:0]             idx_q;
	logic [ppmfd_pkg::TICK_W-1:0] last_q;
	logic                         flag_q;
	logic [ppmfd_pkg::TICK_W-1:0] store_q [NUM_CHANNELS];

	// input stage
	logic            valid_s1;
	ppmfd_pkg::in_t  data_s1;

	// result register
	logic            valid_s2;
	ppmfd_pkg::out_t data_s2;

	logic advance;

	// next-state values
	logic [ppmfd_pkg::TICK_W-1:0] gap;
	logic                         sync_hit, data_hit, waiting, is_capture;
	logic [IDX_W-1:0]             idx_nxt;
	logic                         flag_nxt;
	logic                         store_we;
	logic [ppmfd_pkg::CHAN_W-1:0] rd_chan;
	logic                         rd_in_range;
	ppmfd_pkg::out_t              result;

	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min_q <= ppmfd_pkg::SYNC_MIN_RST;
			sync_max_q <= ppmfd_pkg::SYNC_MAX_RST;
			data_min_q <= ppmfd_pkg::DATA_MIN_RST;
			data_max_q <= ppmfd_pkg::DATA_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppmfd_pkg::CFG_SYNC_MIN: sync_min_q <= cfg_data;
				ppmfd_pkg::CFG_SYNC_MAX: sync_max_q <= cfg_data;
				ppmfd_pkg::CFG_DATA_MIN: data_min_q <= cfg_data;
				ppmfd_pkg::CFG_DATA_MAX: data_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// interval, window checks and frame tracking
	always_comb begin
		is_capture = (ppmfd_pkg::req_t'(data_s1.req_type) == ppmfd_pkg::REQ_CAPTURE);
		gap        = data_s1.capture_time - last_q;
		sync_hit   = (gap > sync_min_q) && (gap < sync_max_q);
		data_hit   = (gap > data_min_q) && (gap < data_max_q);
		waiting    = (idx_q >= IDX_WAIT);
		idx_nxt    = idx_q;
		flag_nxt   = flag_q;
		store_we   = 1'b0;
		if (is_capture) begin
			if (waiting) begin
				if (sync_hit) begin
					idx_nxt = '0;
				end else begin
					flag_nxt = 1'b0;
				end
			end else if (data_hit) begin
				store_we = 1'b1;
				idx_nxt  = idx_q + 1'b1;
				if (idx_nxt == IDX_WAIT) begin
					flag_nxt = 1'b1;
				end
			end else begin
				idx_nxt  = IDX_WAIT;
				flag_nxt = 1'b0;
			end
		end
	end

	// read path and result assembly
	always_comb begin
		rd_chan     = data_s1.channel_number - 1'b1;
		rd_in_range = !is_capture && (data_s1.channel_number != '0)
			&& (data_s1.channel_number <= CHAN_MAX);
		result.frame_valid      = flag_nxt;
		result.channel_in_range = rd_in_range;
		result.channel_value    = rd_in_range ? store_q[rd_chan[SEL_W-1:0]] : '0;
	end

	// state update, once per transaction leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= IDX_WAIT;
			last_q <= '0;
			flag_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				store_q[i] <= PULSE_RST;
			end
		end else if (valid_s1 && advance) begin
			idx_q  <= idx_nxt;
			flag_q <= flag_nxt;
			if (is_capture) begin
				last_q <= data_s1.capture_time;
			end
			if (store_we) begin
				store_q[idx_q[SEL_W-1:0]] <= gap;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2 <= result;
		end
	end

	// channel index never passes the waiting code
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_WAIT)
		else $error("channel index out of range");

	// the valid flag only rises on a completed capture
	a_flag_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flag_q) |-> $past(valid_s1 && advance && is_capture && store_we))
		else $error("frame flag set without a final channel capture");

	// a flag rise leaves the decoder back in wait for sync
	a_flag_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(flag_q) |-> idx_q == IDX_WAIT)
		else $error("frame completed but index not reset to wait");

	// results without a valid channel carry no width
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !data_s2.channel_in_range |-> data_s2.channel_value == '0)
		else $error("nonzero width on out-of-range result");

	// state only moves when a transaction leaves the input stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(idx_q) && $stable(last_q))
		else $error("decoder state changed without a transaction");

endmodule
